@@ rtl/fcc_pkg.sv @@
// shared types, constants and codes of the fan curve controller
`timescale 1ns / 1ps
package fcc_pkg;

    // field widths
    localparam int TEMP_W = 21;
    localparam int RPM_W  = 16;
    localparam int SEC_W  = 32;
    localparam int PT_W   = 7;
    localparam int PWM_W  = 8;
    localparam int DEG_W  = 11;
    localparam int NUM_W  = 14;
    localparam int PROD_W = 28;

    // configuration port
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_POINTS    = 4;
    localparam int CFG_DUTY_BASE = 4;
    localparam int CFG_REG_COUNT = 8;

    // serial divider geometry
    localparam int DIV_W     = 21;
    localparam int DEN_W     = 10;
    localparam int DIV_CNT_W = 5;

    // behavior constants
    localparam logic [DEN_W-1:0] MILLI_PER_DEG = 10'd1000;
    localparam logic [DEG_W-1:0] FAIL_DEG      = 11'd999;
    localparam logic [PT_W-1:0]  FULL_DUTY     = 7'd100;
    localparam logic [PWM_W-1:0] FULL_PWM      = 8'd255;
    // duty * 255 / 100 as duty * (255 * ceil(2^19 / 100)) >> 19, exact for 0..100
    localparam logic [20:0]      PWM_RECIP     = 21'd1336965;
    localparam int               PWM_SHIFT     = 19;

    // curve reset values
    localparam logic [PT_W-1:0] RST_TEMP_0 = 7'd30;
    localparam logic [PT_W-1:0] RST_TEMP_1 = 7'd50;
    localparam logic [PT_W-1:0] RST_TEMP_2 = 7'd65;
    localparam logic [PT_W-1:0] RST_TEMP_3 = 7'd80;
    localparam logic [PT_W-1:0] RST_DUTY_0 = 7'd0;
    localparam logic [PT_W-1:0] RST_DUTY_1 = 7'd30;
    localparam logic [PT_W-1:0] RST_DUTY_2 = 7'd60;
    localparam logic [PT_W-1:0] RST_DUTY_3 = 7'd100;

    typedef logic [PT_W-1:0] pt_t;
    typedef pt_t [CFG_POINTS-1:0] curve_arr_t;

    // curve lookup outcome: either a duty outright or a division to run
    typedef struct packed {
        logic             direct;
        logic [PT_W-1:0]  duty;
        logic             num_neg;
        logic [NUM_W-1:0] num_mag;
        logic [PT_W-1:0]  den;
    } curve_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEG,
        ST_CURVE,
        ST_INTERP,
        ST_SCALE,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/fan_curve_controller_core.sv @@
// fan curve controller top level: curve registers, poll sequencer and write decisions
`timescale 1ns / 1ps
// One poll enters on the s_ channel (valid/ready) and gives exactly one result
// on the m_ channel (valid/ready). Curve points are written through cfg_wr_en,
// cfg_index and cfg_wdata; the user must write them only while no poll is in
// flight, the block itself does not enforce this. Indexes 0..3 are the point
// temperatures, 4..7 the point duties, anything else is ignored.
// A poll runs through one shared bit-serial divider: once to turn the
// millidegree reading into whole degrees, and again when the temperature
// falls inside a sloped curve segment rather than giving a duty straight off
// the curve. A result enters the output register in the same cycle that
// s_ready returns, and polls are worked one at a time.
// Results sit in an output register, so the next poll is taken while a result
// waits; a stalled receiver holds the finished poll in its last step until the
// output register frees up, and s_ready stays low meanwhile.
// Reset (aresetn, synchronous, active low) restores the default curve,
// forgets the enable and the last PWM write, and disarms the kickstart.
module fan_curve_controller_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // poll channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [fcc_pkg::TEMP_W-1:0] s_temp_milli,
    input  logic                          s_sensor_ok,
    input  logic [fcc_pkg::RPM_W-1:0]     s_fan_rpm,
    input  logic [fcc_pkg::SEC_W-1:0]     s_now_seconds,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fcc_pkg::PT_W-1:0]      m_duty_percent,
    output logic                          m_failsafe,
    output logic                          m_kick_active,
    output logic                          m_enable_write,
    output logic                          m_pwm_write,
    output logic [fcc_pkg::PWM_W-1:0]     m_pwm_value,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [fcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcc_pkg::PT_W-1:0]      cfg_wdata
);
    import fcc_pkg::*;

    // curve registers
    curve_arr_t       temps_reg;
    curve_arr_t       duties_reg;

    // sequencer and poll registers
    state_t           state_reg, state_next;
    logic             neg_reg, neg_next;
    logic             ok_reg, ok_next;
    logic [RPM_W-1:0] rpm_reg, rpm_next;
    logic [SEC_W-1:0] now_reg, now_next;
    logic [DEG_W-1:0] deg_reg, deg_next;
    logic             fail_reg, fail_next;
    logic             inum_neg_reg, inum_neg_next;
    logic [PT_W-1:0]  duty_reg, duty_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // controller state
    logic             enable_done_reg, enable_done_next;
    logic             last_valid_reg, last_valid_next;
    logic [PWM_W-1:0] last_pwm_reg, last_pwm_next;
    logic [SEC_W-1:0] kick_dl_reg, kick_dl_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [PT_W-1:0]  o_duty_reg, o_duty_next;
    logic             o_fail_reg, o_fail_next;
    logic             o_kick_reg, o_kick_next;
    logic             o_ew_reg, o_ew_next;
    logic             o_pw_reg, o_pw_next;
    logic [PWM_W-1:0] o_pwm_reg, o_pwm_next;

    // divider hookup
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DEN_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;

    curve_sel_t       csel;
    logic [DIV_W-1:0] temp_mag;
    logic [PWM_W-1:0] target;
    logic [SEC_W-1:0] dl_cand;
    logic             kick;
    logic [PWM_W-1:0] value;
    logic             s_xfer;
    logic             out_free;

    fcc_serdiv u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    fcc_curve u_curve (
        .t_neg  (neg_reg),
        .t_mag  (deg_reg),
        .temps  (temps_reg),
        .duties (duties_reg),
        .sel    (csel)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // magnitude of the reading, the divider works unsigned
    assign temp_mag = s_temp_milli[TEMP_W-1] ? DIV_W'(-s_temp_milli) : DIV_W'(s_temp_milli);

    // scaled pwm target from the registered product
    assign target = prod_reg[PWM_SHIFT +: PWM_W];

    // kickstart arming and expiry
    always_comb begin
        dl_cand = kick_dl_reg;
        if (duty_reg != '0 && rpm_reg == '0 && kick_dl_reg == '0) begin
            dl_cand = now_reg + 1'b1;
        end
        kick  = dl_cand > now_reg;
        value = kick ? FULL_PWM : target;
    end

    // sequencer: next state, divider launches and next values
    always_comb begin
        state_next       = state_reg;
        neg_next         = neg_reg;
        ok_next          = ok_reg;
        rpm_next         = rpm_reg;
        now_next         = now_reg;
        deg_next         = deg_reg;
        fail_next        = fail_reg;
        inum_neg_next    = inum_neg_reg;
        duty_next        = duty_reg;
        prod_next        = prod_reg;
        enable_done_next = enable_done_reg;
        last_valid_next  = last_valid_reg;
        last_pwm_next    = last_pwm_reg;
        kick_dl_next     = kick_dl_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        o_duty_next      = o_duty_reg;
        o_fail_next      = o_fail_reg;
        o_kick_next      = o_kick_reg;
        o_ew_next        = o_ew_reg;
        o_pw_next        = o_pw_reg;
        o_pwm_next       = o_pwm_reg;
        div_start        = 1'b0;
        div_dividend     = temp_mag;
        div_divisor      = MILLI_PER_DEG;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    neg_next   = s_temp_milli[TEMP_W-1];
                    ok_next    = s_sensor_ok;
                    rpm_next   = s_fan_rpm;
                    now_next   = s_now_seconds;
                    div_start  = 1'b1;
                    state_next = ST_DEG;
                end
            end
            ST_DEG: begin
                // whole degrees, truncated toward zero, kept as sign and magnitude
                if (div_done) begin
                    deg_next   = div_quot[DEG_W-1:0];
                    fail_next  = !ok_reg || (!neg_reg && div_quot[DEG_W-1:0] >= FAIL_DEG);
                    state_next = ST_CURVE;
                end
            end
            ST_CURVE: begin
                if (fail_reg) begin
                    duty_next  = FULL_DUTY;
                    state_next = ST_SCALE;
                end else if (csel.direct) begin
                    duty_next  = csel.duty;
                    state_next = ST_SCALE;
                end else begin
                    duty_next     = csel.duty;
                    inum_neg_next = csel.num_neg;
                    div_start     = 1'b1;
                    div_dividend  = DIV_W'(csel.num_mag);
                    div_divisor   = DEN_W'(csel.den);
                    state_next    = ST_INTERP;
                end
            end
            ST_INTERP: begin
                if (div_done) begin
                    duty_next  = inum_neg_reg ? (duty_reg - div_quot[PT_W-1:0])
                                              : (duty_reg + div_quot[PT_W-1:0]);
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                prod_next  = PROD_W'(duty_reg) * PROD_W'(PWM_RECIP);
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // commit the poll once the output register can take it
                if (out_free) begin
                    enable_done_next = 1'b1;
                    kick_dl_next     = kick ? dl_cand : '0;
                    if (!last_valid_reg || last_pwm_reg != value) begin
                        last_valid_next = 1'b1;
                        last_pwm_next   = value;
                    end
                    m_valid_next = 1'b1;
                    o_duty_next  = duty_reg;
                    o_fail_next  = fail_reg;
                    o_kick_next  = kick;
                    o_ew_next    = !enable_done_reg;
                    o_pw_next    = !last_valid_reg || last_pwm_reg != value;
                    o_pwm_next   = value;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            enable_done_reg <= 1'b0;
            last_valid_reg  <= 1'b0;
            last_pwm_reg    <= '0;
            kick_dl_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            enable_done_reg <= enable_done_next;
            last_valid_reg  <= last_valid_next;
            last_pwm_reg    <= last_pwm_next;
            kick_dl_reg     <= kick_dl_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // curve registers, written by index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temps_reg  <= {RST_TEMP_3, RST_TEMP_2, RST_TEMP_1, RST_TEMP_0};
            duties_reg <= {RST_DUTY_3, RST_DUTY_2, RST_DUTY_1, RST_DUTY_0};
        end else if (cfg_wr_en && cfg_index < CFG_IDX_W'(CFG_REG_COUNT)) begin
            if (cfg_index < CFG_IDX_W'(CFG_DUTY_BASE)) begin
                temps_reg[cfg_index[1:0]] <= cfg_wdata;
            end else begin
                duties_reg[cfg_index[1:0]] <= cfg_wdata;
            end
        end
    end

    // poll payload and output payload
    always_ff @(posedge aclk) begin
        neg_reg      <= neg_next;
        ok_reg       <= ok_next;
        rpm_reg      <= rpm_next;
        now_reg      <= now_next;
        deg_reg      <= deg_next;
        fail_reg     <= fail_next;
        inum_neg_reg <= inum_neg_next;
        duty_reg     <= duty_next;
        prod_reg     <= prod_next;
        o_duty_reg   <= o_duty_next;
        o_fail_reg   <= o_fail_next;
        o_kick_reg   <= o_kick_next;
        o_ew_reg     <= o_ew_next;
        o_pw_reg     <= o_pw_next;
        o_pwm_reg    <= o_pwm_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_duty_percent = o_duty_reg;
    assign m_failsafe     = o_fail_reg;
    assign m_kick_active  = o_kick_reg;
    assign m_enable_write = o_ew_reg;
    assign m_pwm_write    = o_pw_reg;
    assign m_pwm_value    = o_pwm_reg;

endmodule

@@ rtl/fcc_serdiv.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module fcc_serdiv (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [fcc_pkg::DIV_W-1:0] dividend,
    input  logic [fcc_pkg::DEN_W-1:0] divisor,
    output logic                      done,
    output logic [fcc_pkg::DIV_W-1:0] quotient
);
    import fcc_pkg::*;

    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = trial >= {1'b0, den_reg};
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next = dividend;
            den_next = divisor;
            rem_next = '0;
            cnt_next = DIV_CNT_W'(DIV_W - 1);
            run_next = 1'b1;
        end else if (run_reg) begin
            dvd_next = {dvd_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // shift registers
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

@@ rtl/fcc_curve.sv @@
// segment lookup on the four-point curve, sets up the interpolation division
`timescale 1ns / 1ps
module fcc_curve (
    input  logic                      t_neg,
    input  logic [fcc_pkg::DEG_W-1:0] t_mag,
    input  fcc_pkg::curve_arr_t       temps,
    input  fcc_pkg::curve_arr_t       duties,
    output fcc_pkg::curve_sel_t       sel
);
    import fcc_pkg::*;

    curve_arr_t       dp;
    logic             le_first;
    logic             ge_last;
    logic             hit;
    logic [1:0]       lo;
    logic [1:0]       hi;
    logic [PT_W-1:0]  dt;
    logic [PT_W-1:0]  off;
    logic [PT_W-1:0]  dd_mag;
    logic             dd_neg;
    logic [NUM_W-1:0] prod;

    always_comb begin
        // duty points above full scale count as full scale
        for (int i = 0; i < CFG_POINTS; i++) begin
            dp[i] = (duties[i] > FULL_DUTY) ? FULL_DUTY : duties[i];
        end

        le_first = t_neg || (t_mag <= DEG_W'(temps[0]));
        ge_last  = !t_neg && (t_mag >= DEG_W'(temps[CFG_POINTS-1]));

        // first segment that holds t wins
        hit = 1'b0;
        lo  = '0;
        for (int i = CFG_POINTS - 2; i >= 0; i--) begin
            if (t_mag >= DEG_W'(temps[i]) && t_mag <= DEG_W'(temps[i+1])) begin
                hit = 1'b1;
                lo  = 2'(i);
            end
        end
        hi = lo + 1'b1;

        dt     = temps[hi] - temps[lo];
        off    = t_mag[PT_W-1:0] - temps[lo];
        dd_neg = dp[hi] < dp[lo];
        dd_mag = dd_neg ? (dp[lo] - dp[hi]) : (dp[hi] - dp[lo]);
        prod   = NUM_W'(dd_mag) * NUM_W'(off);

        sel.direct  = 1'b1;
        sel.duty    = FULL_DUTY;
        sel.num_neg = dd_neg;
        sel.num_mag = prod;
        sel.den     = dt;

        if (le_first) begin
            sel.duty = dp[0];
        end else if (ge_last) begin
            sel.duty = dp[CFG_POINTS-1];
        end else if (hit) begin
            if (dt == '0) begin
                sel.duty = dp[hi];
            end else if (dp[lo] == '0 && t_mag < DEG_W'(temps[hi])) begin
                sel.duty = '0;
            end else begin
                // base duty plus a truncated fraction of the rise or fall
                sel.direct = 1'b0;
                sel.duty   = dp[lo];
            end
        end
    end

endmodule
